// ----- hdl/lrsp_pkg.sv -----
// ----------------------------------------------------------------------------
// lrsp_pkg
// Shared constants, codes and types of the log record stream parser.
// ----------------------------------------------------------------------------
package lrsp_pkg;

	localparam int HASH_BYTES = 32;
	localparam int LEN_BYTES  = 4;

	localparam int BYTE_W   = 8;
	localparam int ROLE_W   = 3;
	localparam int TOPIC_W  = 8;
	localparam int OFF_W    = 5;
	localparam int STATUS_W = 2;
	localparam int LEN_W    = 32;
	localparam int CONS_W   = 33;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOPIC_COUNT   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD_BYTES = 1'b1;

	localparam logic [TOPIC_W-1:0] MAX_TOPIC_COUNT_RST   = 8'd4;
	localparam logic [LEN_W-1:0]   MAX_PAYLOAD_BYTES_RST = '1;

	// byte roles
	localparam logic [ROLE_W-1:0] ROLE_ADDR    = 3'd0;
	localparam logic [ROLE_W-1:0] ROLE_TCOUNT  = 3'd1;
	localparam logic [ROLE_W-1:0] ROLE_TOPIC   = 3'd2;
	localparam logic [ROLE_W-1:0] ROLE_LEN     = 3'd3;
	localparam logic [ROLE_W-1:0] ROLE_DATA    = 3'd4;
	localparam logic [ROLE_W-1:0] ROLE_IGNORED = 3'd5;

	// record status
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_LIMIT = 2'd2;

	typedef enum logic [5:0] {
		PH_ADDR   = 6'b000001,
		PH_TCOUNT = 6'b000010,
		PH_TOPIC  = 6'b000100,
		PH_LEN    = 6'b001000,
		PH_DATA   = 6'b010000,
		PH_PEND   = 6'b100000
	} phase_t;

	// one parse step, from the parser to the output stage
	typedef struct packed {
		logic                has;
		logic [ROLE_W-1:0]   role;
		logic [TOPIC_W-1:0]  topic_number;
		logic [OFF_W-1:0]    byte_offset;
		logic                done_res;
		logic [STATUS_W-1:0] status;
		logic [CONS_W-1:0]   consumed_bytes;
	} result_t;

endpackage

// ----- hdl/lrsp_if.sv -----
// ----------------------------------------------------------------------------
// lrsp_if
// Valid/ready channels of the parser: buffer bytes in, tagged bytes out.
// ----------------------------------------------------------------------------
interface lrsp_in_if;
	import lrsp_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;
	logic              final_byte;

	modport source (output valid, output in_byte, output final_byte, input ready);
	modport sink   (input valid, input in_byte, input final_byte, output ready);
endinterface

interface lrsp_out_if;
	import lrsp_pkg::*;

	logic                valid;
	logic                ready;
	logic [ROLE_W-1:0]   role;
	logic [TOPIC_W-1:0]  topic_number;
	logic [OFF_W-1:0]    byte_offset;
	logic [BYTE_W-1:0]   byte_value;
	logic                done_res;
	logic [STATUS_W-1:0] status;
	logic [CONS_W-1:0]   consumed_bytes;

	modport source (output valid, output role, output topic_number, output byte_offset,
		output byte_value, output done_res, output status, output consumed_bytes,
		input ready);
	modport sink   (input valid, input role, input topic_number, input byte_offset,
		input byte_value, input done_res, input status, input consumed_bytes,
		output ready);
endinterface

// ----- hdl/log_record_stream_parser_core.sv -----
// ----------------------------------------------------------------------------
// log_record_stream_parser_core
// A byte beat is held in the input register, then its result in the result
// register. Throughput: one byte per cycle while no result beat stalls; the
// parse step is combinational logic between the input and result registers.
// Reset: clears the parse state and both stages; limits return to 4 and
// 0xFFFFFFFF.
// ----------------------------------------------------------------------------
module log_record_stream_parser_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lrsp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lrsp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	lrsp_in_if.sink                           byte_ch,
	lrsp_out_if.source                        result_ch
);
	import lrsp_pkg::*;

	// Limit registers. Writes land directly; the host must only write them
	// between records, which the block itself does not enforce.
	logic [TOPIC_W-1:0] max_topic_count_q;
	logic [LEN_W-1:0]   max_payload_bytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_topic_count_q   <= MAX_TOPIC_COUNT_RST;
			max_payload_bytes_q <= MAX_PAYLOAD_BYTES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_TOPIC_COUNT:   max_topic_count_q   <= cfg_wdata[TOPIC_W-1:0];
				CFG_MAX_PAYLOAD_BYTES: max_payload_bytes_q <= cfg_wdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1: input register. It holds one byte beat until the parser
	// can step it into the result register.
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              final_s1;
	logic              advance_s1;

	// Stage 2: result register, the output beat.
	logic                valid_s2;
	logic [ROLE_W-1:0]   role_s2;
	logic [TOPIC_W-1:0]  topic_s2;
	logic [OFF_W-1:0]    off_s2;
	logic [BYTE_W-1:0]   byte_s2;
	logic                done_s2;
	logic [STATUS_W-1:0] status_s2;
	logic [CONS_W-1:0]   cons_s2;

	result_t step_res;

	// Step stage 1 when the result register is free or drains this cycle.
	// A byte that yields no result (trailing bytes) steps regardless.
	assign advance_s1   = valid_s1 && (!valid_s2 || result_ch.ready || !step_res.has);
	assign byte_ch.ready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	// payload: no reset needed
	always_ff @(posedge clk) begin
		if (byte_ch.ready && byte_ch.valid) begin
			byte_s1  <= byte_ch.in_byte;
			final_s1 <= byte_ch.final_byte;
		end
	end

	// One parse step per byte: tags role, offsets and the record decision.
	lrsp_parser u_parser (
		.clk               (clk),
		.arst_n            (arst_n),
		.step_en           (advance_s1),
		.in_byte           (byte_s1),
		.final_byte        (final_s1),
		.max_topic_count   (max_topic_count_q),
		.max_payload_bytes (max_payload_bytes_q),
		.result            (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1 && step_res.has) begin
			valid_s2 <= 1'b1;
		end else if (result_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && step_res.has) begin
			role_s2   <= step_res.role;
			topic_s2  <= step_res.topic_number;
			off_s2    <= step_res.byte_offset;
			byte_s2   <= byte_s1;
			done_s2   <= step_res.done_res;
			status_s2 <= step_res.status;
			cons_s2   <= step_res.consumed_bytes;
		end
	end

	assign result_ch.valid          = valid_s2;
	assign result_ch.role           = role_s2;
	assign result_ch.topic_number   = topic_s2;
	assign result_ch.byte_offset    = off_s2;
	assign result_ch.byte_value     = byte_s2;
	assign result_ch.done_res       = done_s2;
	assign result_ch.status         = status_s2;
	assign result_ch.consumed_bytes = cons_s2;

	// A stalled result beat must not be overwritten by the parser.
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !result_ch.ready |=> valid_s2 && $stable(byte_s2) && $stable(role_s2))
		else $error("result beat changed while stalled");

	// Beats that do not settle the record carry no status and no count.
	a_open_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !done_s2 |-> status_s2 == ST_OK && cons_s2 == '0)
		else $error("status or count on an unsettled beat");

	// Errors report zero consumed bytes.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && done_s2 && status_s2 != ST_OK |-> cons_s2 == '0)
		else $error("nonzero count on an error");

	// Only topic bytes carry a topic number.
	a_topic_num: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && role_s2 != ROLE_TOPIC |-> topic_s2 == '0)
		else $error("topic number outside a topic");

endmodule

// ----- hdl/lrsp_parser.sv -----
// ----------------------------------------------------------------------------
// lrsp_parser
// Record parse state and the combinational step that tags one byte.
// ----------------------------------------------------------------------------
module lrsp_parser (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step_en,
	input  logic [lrsp_pkg::BYTE_W-1:0]      in_byte,
	input  logic                             final_byte,
	input  logic [lrsp_pkg::TOPIC_W-1:0]     max_topic_count,
	input  logic [lrsp_pkg::LEN_W-1:0]       max_payload_bytes,
	output lrsp_pkg::result_t                result
);
	import lrsp_pkg::*;

	logic                idle_q, idle_d;
	phase_t              phase_q, phase_d;
	logic [OFF_W-1:0]    off_q, off_d;
	logic [TOPIC_W-1:0]  topic_total_q, topic_total_d;
	logic [TOPIC_W-1:0]  topic_index_q, topic_index_d;
	logic [LEN_W-1:0]    length_q, length_d;
	logic [LEN_W-1:0]    remain_q, remain_d;
	logic [CONS_W-1:0]   seen_q, seen_d;
	logic                pending_q, pending_d;

	logic [CONS_W-1:0]   seen_inc;
	logic [TOPIC_W-1:0]  topic_next;
	logic [LEN_W-1:0]    len_new;
	logic [LEN_W-1:0]    remain_dec;

	assign seen_inc   = seen_q + CONS_W'(1);
	assign topic_next = topic_index_q + TOPIC_W'(1);
	assign remain_dec = remain_q - LEN_W'(1);
	assign len_new    = length_q | (LEN_W'(in_byte) << {off_q[1:0], 3'b000});

	always_comb begin
		result         = '0;
		result.has     = !idle_q;
		result.status  = ST_OK;
		idle_d         = idle_q;
		phase_d        = phase_q;
		off_d          = off_q;
		topic_total_d  = topic_total_q;
		topic_index_d  = topic_index_q;
		length_d       = length_q;
		remain_d       = remain_q;
		seen_d         = idle_q ? seen_q : seen_inc;
		pending_d      = pending_q;

		if (!idle_q) begin
			case (phase_q)
				PH_ADDR: begin
					result.role        = ROLE_ADDR;
					result.byte_offset = off_q;
					if (off_q == OFF_W'(HASH_BYTES - 1)) begin
						off_d   = '0;
						phase_d = PH_TCOUNT;
					end else begin
						off_d = off_q + OFF_W'(1);
					end
				end
				PH_TCOUNT: begin
					result.role   = ROLE_TCOUNT;
					topic_total_d = in_byte;
					topic_index_d = '0;
					off_d         = '0;
					if (in_byte > max_topic_count) begin
						pending_d = 1'b1;
						phase_d   = PH_PEND;
					end else if (in_byte == '0) begin
						phase_d = PH_LEN;
					end else begin
						phase_d = PH_TOPIC;
					end
				end
				PH_PEND: begin
					result.role = ROLE_IGNORED;
					off_d       = off_q + OFF_W'(1);
					if (off_q >= OFF_W'(LEN_BYTES - 1) && pending_q) begin
						result.done_res = 1'b1;
						result.status   = ST_LIMIT;
					end
				end
				PH_TOPIC: begin
					result.role         = ROLE_TOPIC;
					result.topic_number = topic_index_q;
					result.byte_offset  = off_q;
					if (off_q == OFF_W'(HASH_BYTES - 1)) begin
						off_d         = '0;
						topic_index_d = topic_next;
						if (topic_next >= topic_total_q)
							phase_d = PH_LEN;
					end else begin
						off_d = off_q + OFF_W'(1);
					end
				end
				PH_LEN: begin
					result.role        = ROLE_LEN;
					result.byte_offset = off_q;
					length_d           = len_new;
					if (off_q >= OFF_W'(LEN_BYTES - 1)) begin
						off_d = '0;
						if (len_new > max_payload_bytes) begin
							result.done_res = 1'b1;
							result.status   = ST_LIMIT;
						end else if (len_new == '0) begin
							result.done_res       = 1'b1;
							result.consumed_bytes = seen_inc;
						end else begin
							remain_d = len_new;
							phase_d  = PH_DATA;
						end
					end else begin
						off_d = off_q + OFF_W'(1);
					end
				end
				PH_DATA: begin
					result.role = ROLE_DATA;
					remain_d    = remain_dec;
					if (remain_dec == '0) begin
						result.done_res       = 1'b1;
						result.consumed_bytes = seen_inc;
					end
				end
				default: begin
					result.has = 1'b0;
					seen_d     = seen_q;
				end
			endcase

			// buffer ended before the record settled
			if (result.has && !result.done_res && final_byte) begin
				result.done_res       = 1'b1;
				result.status         = ST_SHORT;
				result.consumed_bytes = '0;
			end
			if (result.done_res)
				idle_d = 1'b1;
		end

		// the last byte of a buffer always restarts the parse
		if (final_byte) begin
			idle_d        = 1'b0;
			phase_d       = PH_ADDR;
			off_d         = '0;
			topic_total_d = '0;
			topic_index_d = '0;
			length_d      = '0;
			remain_d      = '0;
			seen_d        = '0;
			pending_d     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q        <= 1'b0;
			phase_q       <= PH_ADDR;
			off_q         <= '0;
			topic_total_q <= '0;
			topic_index_q <= '0;
			length_q      <= '0;
			remain_q      <= '0;
			seen_q        <= '0;
			pending_q     <= 1'b0;
		end else if (step_en) begin
			idle_q        <= idle_d;
			phase_q       <= phase_d;
			off_q         <= off_d;
			topic_total_q <= topic_total_d;
			topic_index_q <= topic_index_d;
			length_q      <= length_d;
			remain_q      <= remain_d;
			seen_q        <= seen_d;
			pending_q     <= pending_d;
		end
	end

endmodule
